FILE: rtl/irg_pkg.sv
// Shared types, constants and helper functions of the island run grouper.
`default_nettype none

package irg_pkg;

	localparam int ID_W    = 32;
	localparam int CNT_W   = 17;
	localparam int BOUND_W = 28;
	localparam int QDEPTH  = 4;

	// Saturation limit of every count and offset
	localparam logic [CNT_W-1:0] MAX_PAIRS = 17'd65536;

	// Record kinds
	localparam logic KIND_ISLAND = 1'b0;
	localparam logic KIND_LEVEL  = 1'b1;

	// Configuration register indexes
	localparam logic REG_DEPTH    = 1'b0;
	localparam logic REG_CLASSIFY = 1'b1;

	localparam logic [3:0] DEPTH_RESET    = 4'd5;
	localparam logic       CLASSIFY_RESET = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0] island_id;
		logic            last_item;
	} item_t;

	typedef struct packed {
		logic             record_kind;
		logic [ID_W-1:0]  record_id;
		logic [CNT_W-1:0] record_count;
		logic [CNT_W-1:0] record_offset;
		logic [CNT_W-1:0] total_islands;
		logic             last_result;
	} result_t;

	// One closed run, handed from the front to the back
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] len;
		logic [CNT_W-1:0] start;
		logic             fin;
	} cmd_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
		sat_inc = (a >= MAX_PAIRS) ? MAX_PAIRS : a + CNT_W'(1);
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = (s > {1'b0, MAX_PAIRS}) ? MAX_PAIRS : s[CNT_W-1:0];
	endfunction

	// Bound of level i at depth d: octal digits set at places d-1-i .. d-1
	function automatic logic [BOUND_W-1:0] level_bound(input logic [3:0] d, input int i);
		logic [BOUND_W-1:0] b;
		int dd;
		b = '0;
		dd = int'(d);
		for (int p = 0; p < 10; p++) begin
			if (p <= dd - 1 && p >= dd - 1 - i) begin
				b[3*p] = 1'b1;
			end
		end
		level_bound = b;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/island_run_grouper.sv
// Top level of the island run grouper: front end, command queue and record builder.
//
// Input channel: push/full queue interface, one pair beat (island id plus a
// last-item mark) per cycle. Output channel: empty/pop queue interface; the
// oldest result beat sits on result while empty is low.
// Each maximal run of equal ids closes into one island record. With level
// classification on, the last beat of a stream is followed by one level
// record per configured level (level count and prefix-sum offset).
// An island record is registered in the command queue and then in the output
// register before it is on result. Throughput: one pair beat per cycle while full
// is low; an id change on the last beat holds input off until the one-pair final
// run enters the queue. Output is one record per cycle while the receiver pops.
// A four-entry command queue sits between front and back; input stalls (full)
// only when that queue is full or the final run waits to enter it.
// A stalled receiver holds the current result beat; the back end stops and
// the queue fills, then full rises.
// Reset clears the run tracking flags, counts, the queue occupancy and the output
// valid flag; the configuration returns to depth 5 with classification on.
// Configuration is written through wr_en/wr_index/wr_data while idle.
`default_nettype none

module island_run_grouper #(
	parameter int MAX_LEVELS = 10
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	output logic                  full,
	input  wire  irg_pkg::item_t  item,
	output logic                  empty,
	input  wire                   pop,
	output irg_pkg::result_t      result,
	input  wire                   wr_en,
	input  wire                   wr_index,
	input  wire  [3:0]            wr_data
);
	import irg_pkg::*;

	logic enq;
	cmd_t enq_data;
	logic q_full;
	logic deq;
	cmd_t deq_data;
	logic has_data;

	irg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.enq      (enq),
		.enq_data (enq_data),
		.q_full   (q_full)
	);

	irg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (enq),
		.enq_data (enq_data),
		.is_full  (q_full),
		.deq      (deq),
		.deq_data (deq_data),
		.has_data (has_data)
	);

	irg_back #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.has_data (has_data),
		.deq_data (deq_data),
		.deq      (deq),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

`default_nettype wire

FILE: rtl/irg_front.sv
// Front end: accepts pair beats, tracks the current run and emits closed runs.
`default_nettype none

module irg_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  wire  irg_pkg::item_t item,
	output logic                enq,
	output irg_pkg::cmd_t       enq_data,
	input  wire                 q_full
);
	import irg_pkg::*;

	logic             first_seen_q;
	logic             pend_q;
	logic [ID_W-1:0]  run_id_q;
	logic [CNT_W-1:0] run_len_q;
	logic [CNT_W-1:0] run_start_q;

	logic             accept;
	logic             first_seen_d;
	logic             pend_d;
	logic             run_load;
	logic [ID_W-1:0]  run_id_d;
	logic [CNT_W-1:0] run_len_d;
	logic [CNT_W-1:0] run_start_d;

	// Hold input while the final one-pair run waits or the queue has no room
	assign full   = pend_q | q_full;
	assign accept = push & ~full;

	// Next run state and the closed run to enqueue
	always_comb begin
		enq          = 1'b0;
		enq_data     = '{id: run_id_q, len: run_len_q, start: run_start_q, fin: 1'b1};
		first_seen_d = first_seen_q;
		pend_d       = pend_q;
		run_load     = 1'b0;
		run_id_d     = run_id_q;
		run_len_d    = run_len_q;
		run_start_d  = run_start_q;
		if (pend_q && !q_full) begin
			enq          = 1'b1;
			pend_d       = 1'b0;
			first_seen_d = 1'b0;
		end else if (accept) begin
			run_load = 1'b1;
			if (!first_seen_q) begin
				run_id_d    = item.island_id;
				run_len_d   = CNT_W'(1);
				run_start_d = '0;
			end else if (item.island_id == run_id_q) begin
				run_len_d = sat_inc(run_len_q);
			end else begin
				enq          = 1'b1;
				enq_data.fin = 1'b0;
				run_id_d     = item.island_id;
				run_len_d    = CNT_W'(1);
				run_start_d  = sat_add(run_start_q, run_len_q);
			end
			if (item.last_item) begin
				if (enq) begin
					// Id change on the last beat: the new run is held pending until the queue has room
					pend_d       = 1'b1;
					first_seen_d = 1'b1;
				end else begin
					enq          = 1'b1;
					enq_data     = '{id: run_id_d, len: run_len_d, start: run_start_d,
						fin: 1'b1};
					first_seen_d = 1'b0;
				end
			end else begin
				first_seen_d = 1'b1;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_seen_q <= 1'b0;
			pend_q       <= 1'b0;
		end else begin
			first_seen_q <= first_seen_d;
			pend_q       <= pend_d;
		end
	end

	// Run payload
	always_ff @(posedge clk) begin
		if (run_load) begin
			run_id_q    <= run_id_d;
			run_len_q   <= run_len_d;
			run_start_q <= run_start_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/irg_queue.sv
// Short command queue that decouples the front end from the record builder.
`default_nettype none

module irg_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 enq,
	input  wire  irg_pkg::cmd_t enq_data,
	output logic                is_full,
	input  wire                 deq,
	output irg_pkg::cmd_t       deq_data,
	output logic                has_data
);
	import irg_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);

	cmd_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign is_full  = (count_q == (PTR_W+1)'(QDEPTH));
	assign has_data = (count_q != '0);
	assign deq_data = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (enq && !deq) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (deq && !enq) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= enq_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/irg_back.sv
// Back end: classifies closed islands, keeps level counts and builds result beats.
`default_nettype none

module irg_back #(
	parameter int MAX_LEVELS = 10
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   has_data,
	input  wire  irg_pkg::cmd_t   deq_data,
	output logic                  deq,
	input  wire                   wr_en,
	input  wire                   wr_index,
	input  wire  [3:0]            wr_data,
	input  wire                   pop,
	output logic                  empty,
	output irg_pkg::result_t      result
);
	import irg_pkg::*;

	localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam logic [3:0] MAX_LVL_D = 4'(MAX_LEVELS);

	logic [3:0]       depth_q;
	logic             classify_q;
	logic             out_valid_q;
	result_t          out_q;
	logic             burst_q;
	logic [LVL_W-1:0] lvl_q;
	logic [CNT_W-1:0] off_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] cnt_q [MAX_LEVELS];

	logic             load_ok;
	logic             do_level;
	logic             lvl_end;
	logic [MAX_LEVELS-1:0] hit;
	logic             cls_hit;
	logic [LVL_W-1:0] cls_idx;
	logic [LVL_W-1:0] rd_idx;
	logic [CNT_W-1:0] rd_cnt;
	logic [CNT_W-1:0] total_inc;
	logic [3:0]       depth_d;

	assign empty   = ~out_valid_q;
	assign result  = out_q;
	assign load_ok = ~out_valid_q | pop;
	assign do_level = burst_q & load_ok;
	assign deq     = ~burst_q & has_data & load_ok;
	assign lvl_end = (4'(lvl_q) + 4'd1 == depth_q);
	assign total_inc = sat_inc(total_q);

	// Clamp a written depth to the supported range
	always_comb begin
		if (wr_data == 4'd0) begin
			depth_d = 4'd1;
		end else if (wr_data > MAX_LVL_D) begin
			depth_d = MAX_LVL_D;
		end else begin
			depth_d = wr_data;
		end
	end

	// Compare the island id against every level bound, take the first hit
	always_comb begin
		cls_hit = 1'b0;
		cls_idx = '0;
		for (int j = 0; j < MAX_LEVELS; j++) begin
			hit[j] = (4'(j) < depth_q) &&
				(deq_data.id < {{(ID_W-BOUND_W){1'b0}}, level_bound(depth_q, j)});
		end
		for (int j = MAX_LEVELS - 1; j >= 0; j--) begin
			if (hit[j]) begin
				cls_hit = 1'b1;
				cls_idx = LVL_W'(j);
			end
		end
	end

	assign rd_idx = burst_q ? lvl_q : cls_idx;
	assign rd_cnt = cnt_q[rd_idx];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= DEPTH_RESET;
			classify_q <= CLASSIFY_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_DEPTH:    depth_q    <= depth_d;
				REG_CLASSIFY: classify_q <= wr_data[0];
				default:      ;
			endcase
		end
	end

	// Stream state: level burst, counts and island total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			burst_q     <= 1'b0;
			lvl_q       <= '0;
			off_q       <= '0;
			total_q     <= '0;
			for (int j = 0; j < MAX_LEVELS; j++) begin
				cnt_q[j] <= '0;
			end
		end else if (do_level) begin
			out_valid_q <= 1'b1;
			if (lvl_end) begin
				burst_q <= 1'b0;
				lvl_q   <= '0;
				off_q   <= '0;
				total_q <= '0;
				for (int j = 0; j < MAX_LEVELS; j++) begin
					cnt_q[j] <= '0;
				end
			end else begin
				lvl_q <= lvl_q + LVL_W'(1);
				off_q <= sat_add(off_q, rd_cnt);
			end
		end else if (deq) begin
			out_valid_q <= 1'b1;
			if (deq_data.fin && !classify_q) begin
				total_q <= '0;
				for (int j = 0; j < MAX_LEVELS; j++) begin
					cnt_q[j] <= '0;
				end
			end else begin
				total_q <= total_inc;
				if (classify_q && cls_hit) begin
					cnt_q[cls_idx] <= sat_inc(rd_cnt);
				end
				if (deq_data.fin) begin
					burst_q <= 1'b1;
				end
			end
		end else if (load_ok) begin
			out_valid_q <= 1'b0;
		end
	end

	// Build the result beat
	always_ff @(posedge clk) begin
		if (do_level) begin
			out_q.record_kind   <= KIND_LEVEL;
			out_q.record_id     <= ID_W'(lvl_q);
			out_q.record_count  <= rd_cnt;
			out_q.record_offset <= off_q;
			out_q.total_islands <= total_q;
			out_q.last_result   <= lvl_end;
		end else if (deq) begin
			out_q.record_kind   <= KIND_ISLAND;
			out_q.record_id     <= deq_data.id;
			out_q.record_count  <= deq_data.len;
			out_q.record_offset <= deq_data.start;
			out_q.total_islands <= total_inc;
			out_q.last_result   <= deq_data.fin & ~classify_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/irg_checker.sv
// Port-level checks on the island run grouper's result channel, bound to the top level.
`default_nettype none

module irg_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   pop,
	input wire                   empty,
	input wire irg_pkg::result_t result
);
	import irg_pkg::*;

	// A waiting result beat holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result beat changed while stalled");

	// An island always holds at least one pair
	a_island_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.record_kind == KIND_ISLAND) |-> (result.record_count != '0))
		else $error("island record with zero length");

	// The first level starts at offset zero
	a_level0_off: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.record_kind == KIND_LEVEL && result.record_id == '0)
		|-> (result.record_offset == '0))
		else $error("level zero offset not zero");

	// Level offsets never exceed the island total
	a_level_off: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.record_kind == KIND_LEVEL)
		|-> (result.record_offset <= result.total_islands))
		else $error("level offset above island total");

endmodule

bind island_run_grouper irg_checker u_irg_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.pop    (pop),
	.empty  (empty),
	.result (result)
);

`default_nettype wire
